// ----- sv/arp_request_responder_core_macros.svh -----
// ---------------------------------------------------------------------------
// ARP request responder assertion macros
// Concurrent assertion wrappers for the responder; they are compiled out
// when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef ARP_REQUEST_RESPONDER_CORE_MACROS_SVH
`define ARP_REQUEST_RESPONDER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define ARPR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ARPR_ASSERT(lbl, prop, msg) \
  `ARPR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ARPR_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ARPR_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- sv/arpr_pkg.sv -----
// ---------------------------------------------------------------------------
// ARP request responder package
// Codes, frame layout constants, shared types and byte selection helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package arpr_pkg;

  localparam logic [1:0] MODE_RX   = 2'd0;
  localparam logic [1:0] MODE_SEND = 2'd1;
  localparam logic [1:0] MODE_FREE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ARP   = 3'd1;
  localparam logic [2:0] ST_NOT_OURS  = 3'd2;
  localparam logic [2:0] ST_BUSY      = 3'd3;
  localparam logic [2:0] ST_MALFORMED = 3'd4;
  localparam logic [2:0] ST_FREE_BAD  = 3'd5;

  localparam logic [1:0] BUF_FREE = 2'd0;
  localparam logic [1:0] BUF_PEND = 2'd1;
  localparam logic [1:0] BUF_RSVD = 2'd2;

  localparam logic [1:0] CFG_MY_MAC  = 2'd0;
  localparam logic [1:0] CFG_MY_IP   = 2'd1;
  localparam logic [1:0] CFG_BUF_IDX = 2'd2;

  localparam logic [7:0]  ETH_TYPE_HI = 8'h08;
  localparam logic [7:0]  ETH_TYPE_LO = 8'h06;
  localparam logic [7:0]  OPER_REPLY  = 8'h02;
  localparam logic [5:0]  POS_MAX     = 6'd63;
  localparam logic [5:0]  POS_TYPE_HI = 6'd12;
  localparam logic [5:0]  POS_TYPE_LO = 6'd13;
  localparam logic [5:0]  POS_LAST    = 6'd41;
  localparam logic [10:0] REPLY_LEN   = 11'd42;

  typedef struct packed {
    logic        is_arp;
    logic        malformed;
    logic [31:0] target_ip;
    logic [47:0] source_mac;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
  } rx_frame_t;

  typedef struct packed {
    logic       active;
    logic [7:0] data;
    logic       last;
  } tx_out_t;

  function automatic logic [7:0] hdr_expect(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd1:    r = 8'h01;
      3'd2:    r = 8'h08;
      3'd4:    r = 8'h06;
      3'd5:    r = 8'h04;
      3'd7:    r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] mac_byte(input logic [47:0] v, input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = v[47:40];
      3'd1:    r = v[39:32];
      3'd2:    r = v[31:24];
      3'd3:    r = v[23:16];
      3'd4:    r = v[15:8];
      3'd5:    r = v[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/arp_request_responder_core.sv -----
// ---------------------------------------------------------------------------
// ARP request responder core
// Answers ARP requests for the configured IPv4 address with one reply buffer.
// ---------------------------------------------------------------------------
// Items enter on the in_valid_i / in_ready_o channel: received frame bytes,
// send attempts and buffer free notifications. Results leave on the
// out_valid_o / out_ready_i channel, each transaction carrying either a status
// or one byte of the reply frame. An item is registered on acceptance and
// handled once the reply generator is idle and the output register is free;
// handling writes its result into the output register. Frame bytes, free
// notifications and failed send attempts are taken at one per cycle while
// the output is not held. A successful send occupies the reply generator for
// 42 output transactions, one byte per cycle while out_ready_i is high; new
// items wait. When the receiver holds out_ready_i low the output register
// keeps its transaction and the item register holds its item; in_ready_o
// drops once both are full. Reset clears the parser, the buffer state, the
// counters and the configuration registers; the block is ready at once.
// Configuration writes are taken on any cycle in which cfg_we_i is high.
// ---------------------------------------------------------------------------
`default_nettype none

`include "arp_request_responder_core_macros.svh"

module arp_request_responder_core
  import arpr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        rx_last_i,
  input  wire logic        queue_ready_i,
  input  wire logic [10:0] freed_length_i,
  input  wire logic [7:0]  freed_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [2:0]       status_o,
  output logic [7:0]       tx_byte_o,
  output logic             tx_last_o,
  output logic [31:0]      arp_rx_count_o,
  output logic [31:0]      reply_tx_count_o
);

  logic [47:0] my_mac_q;
  logic [31:0] my_ip_q;
  logic [7:0]  buf_idx_q;

  logic        item_valid_q;
  logic [1:0]  mode_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        qrdy_q;
  logic [10:0] flen_q;
  logic [7:0]  fidx_q;

  logic [1:0]  buf_q, buf_d;
  logic [31:0] arp_cnt_q, arp_cnt_d;
  logic [31:0] rep_cnt_q, rep_cnt_d;
  logic [47:0] rep_dmac_q;
  logic [47:0] rep_tmac_q;
  logic [31:0] rep_tip_q;
  logic        capture;

  logic        out_valid_q;
  logic        kind_q;
  logic [2:0]  status_q;
  logic [7:0]  tx_byte_q;
  logic        tx_last_q;
  logic [31:0] arp_out_q;
  logic [31:0] rep_out_q;

  logic        out_free;
  logic        item_go;
  logic        in_accept;
  logic        tx_start;
  logic        stat_valid;
  logic [2:0]  stat_code;

  rx_frame_t   frame;
  tx_out_t     tx;

  assign out_free   = !out_valid_q || out_ready_i;
  assign item_go    = item_valid_q && !tx.active && out_free;
  assign in_ready_o = !item_valid_q || item_go;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_mac_q  <= '0;
      my_ip_q   <= '0;
      buf_idx_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MY_MAC:  my_mac_q  <= cfg_data_i;
        CFG_MY_IP:   my_ip_q   <= cfg_data_i[31:0];
        CFG_BUF_IDX: buf_idx_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (item_go) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      byte_q <= rx_byte_i;
      last_q <= rx_last_i;
      qrdy_q <= queue_ready_i;
      flen_q <= freed_length_i;
      fidx_q <= freed_index_i;
    end
  end

  arpr_rx_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (item_go && (mode_q == MODE_RX)),
    .rx_byte_i (byte_q),
    .rx_last_i (last_q),
    .frame_o   (frame)
  );

  always_comb begin
    buf_d      = buf_q;
    arp_cnt_d  = arp_cnt_q;
    rep_cnt_d  = rep_cnt_q;
    capture    = 1'b0;
    tx_start   = 1'b0;
    stat_valid = 1'b0;
    stat_code  = ST_OK;
    if (item_go) begin
      case (mode_q)
        MODE_RX: begin
          if (last_q) begin
            stat_valid = 1'b1;
            if (!frame.is_arp) begin
              stat_code = ST_NOT_ARP;
            end else begin
              arp_cnt_d = arp_cnt_q + 32'd1;
              if (frame.malformed) begin
                stat_code = ST_MALFORMED;
              end else if (frame.target_ip != my_ip_q) begin
                stat_code = ST_NOT_OURS;
              end else if (buf_q != BUF_FREE) begin
                stat_code = ST_BUSY;
              end else begin
                capture = 1'b1;
                buf_d   = BUF_PEND;
              end
            end
          end
        end
        MODE_SEND: begin
          if (buf_q == BUF_PEND && qrdy_q) begin
            tx_start  = 1'b1;
            buf_d     = BUF_RSVD;
            rep_cnt_d = rep_cnt_q + 32'd1;
          end
        end
        MODE_FREE: begin
          stat_valid = 1'b1;
          if (flen_q == REPLY_LEN && fidx_q == buf_idx_q && buf_q == BUF_RSVD) begin
            buf_d = BUF_FREE;
          end else begin
            stat_code = ST_FREE_BAD;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q     <= BUF_FREE;
      arp_cnt_q <= '0;
      rep_cnt_q <= '0;
    end else begin
      buf_q     <= buf_d;
      arp_cnt_q <= arp_cnt_d;
      rep_cnt_q <= rep_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_dmac_q <= '0;
      rep_tmac_q <= '0;
      rep_tip_q  <= '0;
    end else if (capture) begin
      rep_dmac_q <= frame.source_mac;
      rep_tmac_q <= frame.sender_mac;
      rep_tip_q  <= frame.sender_ip;
    end
  end

  arpr_tx_gen u_tx_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (tx_start),
    .advance_i    (out_free),
    .my_mac_i     (my_mac_q),
    .my_ip_i      (my_ip_q),
    .dest_mac_i   (rep_dmac_q),
    .target_mac_i (rep_tmac_q),
    .target_ip_i  (rep_tip_q),
    .tx_o         (tx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= tx.active || stat_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (tx.active) begin
        kind_q    <= 1'b1;
        status_q  <= ST_OK;
        tx_byte_q <= tx.data;
        tx_last_q <= tx.last;
        arp_out_q <= arp_cnt_q;
        rep_out_q <= rep_cnt_q;
      end else if (stat_valid) begin
        kind_q    <= 1'b0;
        status_q  <= stat_code;
        tx_byte_q <= '0;
        tx_last_q <= 1'b0;
        arp_out_q <= arp_cnt_d;
        rep_out_q <= rep_cnt_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign status_o         = status_q;
  assign tx_byte_o        = tx_byte_q;
  assign tx_last_o        = tx_last_q;
  assign arp_rx_count_o   = arp_out_q;
  assign reply_tx_count_o = rep_out_q;

  `ARPR_ASSERT(a_start_reserves, tx_start |=> (buf_q == BUF_RSVD), "send did not reserve buffer")
  `ARPR_ASSERT(a_active_reserved, tx.active |-> (buf_q == BUF_RSVD), "reply run without reserved buffer")
  `ARPR_ASSERT(a_last_ends_run, (out_valid_o && out_ready_i && kind_o && tx_last_o) |-> !tx.active, "reply run continues past last byte")
  `ARPR_ASSERT(a_rep_cnt_start, !$stable(rep_cnt_q) |-> $past(tx_start), "reply count changed without a send")

endmodule

`default_nettype wire

// ----- sv/arpr_rx_parser.sv -----
// ---------------------------------------------------------------------------
// ARP receive parser
// Tracks the byte position in a received frame, captures the addresses and
// checks the Ethernet type and ARP request header.
// ---------------------------------------------------------------------------
`default_nettype none

module arpr_rx_parser
  import arpr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       byte_en_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       rx_last_i,
  output rx_frame_t       frame_o
);

  logic [5:0]  pos_q, pos_d;
  logic        is_arp_q, is_arp_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [47:0] src_mac_q, src_mac_d;
  logic [47:0] snd_mac_q, snd_mac_d;
  logic [31:0] snd_ip_q, snd_ip_d;
  logic [31:0] tgt_ip_q, tgt_ip_d;

  always_comb begin
    is_arp_d  = is_arp_q;
    hdr_ok_d  = hdr_ok_q;
    src_mac_d = src_mac_q;
    snd_mac_d = snd_mac_q;
    snd_ip_d  = snd_ip_q;
    tgt_ip_d  = tgt_ip_q;
    if (pos_q >= 6'd6 && pos_q < 6'd12) begin
      src_mac_d = {src_mac_q[39:0], rx_byte_i};
    end else if (pos_q == POS_TYPE_HI) begin
      is_arp_d = (rx_byte_i == ETH_TYPE_HI);
    end else if (pos_q == POS_TYPE_LO) begin
      is_arp_d = is_arp_q && (rx_byte_i == ETH_TYPE_LO);
    end else if (pos_q >= 6'd14 && pos_q < 6'd22) begin
      if (rx_byte_i != hdr_expect(3'(pos_q - 6'd14))) begin
        hdr_ok_d = 1'b0;
      end
    end else if (pos_q >= 6'd22 && pos_q < 6'd28) begin
      snd_mac_d = {snd_mac_q[39:0], rx_byte_i};
    end else if (pos_q >= 6'd28 && pos_q < 6'd32) begin
      snd_ip_d = {snd_ip_q[23:0], rx_byte_i};
    end else if (pos_q >= 6'd38 && pos_q < 6'd42) begin
      tgt_ip_d = {tgt_ip_q[23:0], rx_byte_i};
    end
    if (rx_last_i) begin
      pos_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 6'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_comb begin
    frame_o.is_arp     = is_arp_d && (pos_q >= POS_TYPE_LO);
    frame_o.malformed  = (pos_q < POS_LAST) || !hdr_ok_d;
    frame_o.target_ip  = tgt_ip_d;
    frame_o.source_mac = src_mac_q;
    frame_o.sender_mac = snd_mac_q;
    frame_o.sender_ip  = snd_ip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      is_arp_q  <= 1'b0;
      hdr_ok_q  <= 1'b1;
      src_mac_q <= '0;
      snd_mac_q <= '0;
      snd_ip_q  <= '0;
      tgt_ip_q  <= '0;
    end else if (byte_en_i) begin
      pos_q     <= pos_d;
      is_arp_q  <= rx_last_i ? 1'b0 : is_arp_d;
      hdr_ok_q  <= rx_last_i ? 1'b1 : hdr_ok_d;
      src_mac_q <= src_mac_d;
      snd_mac_q <= snd_mac_d;
      snd_ip_q  <= snd_ip_d;
      tgt_ip_q  <= tgt_ip_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/arpr_tx_gen.sv -----
// ---------------------------------------------------------------------------
// ARP reply generator
// Steps through the 42 bytes of the reply frame, one byte per output slot.
// ---------------------------------------------------------------------------
`default_nettype none

module arpr_tx_gen
  import arpr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        advance_i,
  input  wire logic [47:0] my_mac_i,
  input  wire logic [31:0] my_ip_i,
  input  wire logic [47:0] dest_mac_i,
  input  wire logic [47:0] target_mac_i,
  input  wire logic [31:0] target_ip_i,
  output tx_out_t          tx_o
);

  logic [5:0] pos_q;
  logic       active_q;
  logic [7:0] data;

  always_comb begin
    if (pos_q < 6'd6) begin
      data = mac_byte(dest_mac_i, pos_q[2:0]);
    end else if (pos_q < 6'd12) begin
      data = mac_byte(my_mac_i, 3'(pos_q - 6'd6));
    end else if (pos_q == POS_TYPE_HI) begin
      data = ETH_TYPE_HI;
    end else if (pos_q == POS_TYPE_LO) begin
      data = ETH_TYPE_LO;
    end else if (pos_q < 6'd22) begin
      data = (pos_q == 6'd21) ? OPER_REPLY : hdr_expect(3'(pos_q - 6'd14));
    end else if (pos_q < 6'd28) begin
      data = mac_byte(my_mac_i, 3'(pos_q - 6'd22));
    end else if (pos_q < 6'd32) begin
      data = ip_byte(my_ip_i, 2'(pos_q - 6'd28));
    end else if (pos_q < 6'd38) begin
      data = mac_byte(target_mac_i, 3'(pos_q - 6'd32));
    end else begin
      data = ip_byte(target_ip_i, 2'(pos_q - 6'd38));
    end
  end

  assign tx_o.active = active_q;
  assign tx_o.data   = data;
  assign tx_o.last   = (pos_q == POS_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      pos_q    <= '0;
    end else if (active_q && advance_i) begin
      if (pos_q == POS_LAST) begin
        active_q <= 1'b0;
        pos_q    <= '0;
      end else begin
        pos_q <= pos_q + 6'd1;
      end
    end
  end

endmodule

`default_nettype wire
